@@ hw/rtl/fpbc_pkg.sv @@
// Shared types and constants for the flow packet and byte counter table.
`timescale 1ns / 1ps

package fpbc_pkg;

    localparam int TALLY_BITS  = 64;
    localparam int LEN_BITS    = 16;
    localparam int MODE_BITS   = 2;
    localparam int ENTRY_BITS  = 1 + 2 * TALLY_BITS;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_BITS-1:0] MODE_COUNT  = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADD    = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_REMOVE = 2'd2;

    typedef enum logic [1:0] {
        OP_COUNT,
        OP_ADD,
        OP_REMOVE,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_PRESENT = 2'd1,
        ST_ABSENT  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_APPLY
    } back_state_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

endpackage

@@ hw/rtl/fpbc_front.sv @@
// Front end: accepts input beats, classifies the mode and queues the commands.
`timescale 1ns / 1ps

module fpbc_front
    import fpbc_pkg::*;
#(
    parameter int ID_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [MODE_BITS-1:0] mode,
    input  logic [ID_BITS-1:0]   counter_id,
    input  logic [LEN_BITS-1:0]  packet_length,
    input  back_status_t         bk_status,
    output logic                 q_valid,
    output op_t                  q_op,
    output logic [ID_BITS-1:0]   q_idx,
    output logic [LEN_BITS-1:0]  q_len,
    input  logic                 q_pop
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    op_t                 op_q_reg  [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  idx_q_reg [QUEUE_DEPTH];
    logic [LEN_BITS-1:0] len_q_reg [QUEUE_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    op_t  in_op;
    logic push;
    logic pop;

    always_comb
    begin
        unique case (mode)
            MODE_COUNT:  in_op = OP_COUNT;
            MODE_ADD:    in_op = OP_ADD;
            MODE_REMOVE: in_op = OP_REMOVE;
            default:     in_op = OP_NONE;
        endcase
    end

    assign in_stall = (count_reg == CNT_BITS'(QUEUE_DEPTH)) || bk_status.clearing;
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_pop && q_valid;

    assign q_op  = op_q_reg[rd_ptr_reg];
    assign q_idx = idx_q_reg[rd_ptr_reg];
    assign q_len = len_q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q_reg[wr_ptr_reg]  <= in_op;
            idx_q_reg[wr_ptr_reg] <= counter_id;
            len_q_reg[wr_ptr_reg] <= packet_length;
        end
    end

endmodule

@@ hw/rtl/fpbc_back.sv @@
// Back end: clears the table, runs each command against the counter memory.
`timescale 1ns / 1ps

module fpbc_back
    import fpbc_pkg::*;
#(
    parameter int ID_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    input  op_t                   q_op,
    input  logic [ID_BITS-1:0]    q_idx,
    input  logic [LEN_BITS-1:0]   q_len,
    output logic                  q_pop,
    output back_status_t          bk_status,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [TALLY_BITS-1:0] packets_seen,
    output logic [TALLY_BITS-1:0] bytes_seen
);

    localparam int DEPTH = 1 << ID_BITS;

    logic [ENTRY_BITS-1:0] mem [DEPTH];

    back_state_t state_reg, state_next;
    logic [ID_BITS-1:0] clear_addr_reg, clear_addr_next;

    op_t                   op_reg, op_next;
    logic [ID_BITS-1:0]    idx_reg, idx_next;
    logic [LEN_BITS-1:0]   len_reg, len_next;
    logic [ENTRY_BITS-1:0] rd_data_reg;

    logic                  out_valid_reg, out_valid_next;
    status_t               status_reg, status_next;
    logic [TALLY_BITS-1:0] pk_out_reg, pk_out_next;
    logic [TALLY_BITS-1:0] by_out_reg, by_out_next;

    logic                  rd_en;
    logic [ID_BITS-1:0]    rd_addr;
    logic                  wr_en;
    logic [ID_BITS-1:0]    wr_addr;
    logic [ENTRY_BITS-1:0] wr_data;

    logic                  entry_open;
    logic [TALLY_BITS-1:0] entry_pk;
    logic [TALLY_BITS-1:0] entry_by;
    logic [TALLY_BITS-1:0] sum_pk;
    logic [TALLY_BITS-1:0] sum_by;
    logic                  out_free;

    assign entry_open = rd_data_reg[ENTRY_BITS-1];
    assign entry_pk   = rd_data_reg[2*TALLY_BITS-1:TALLY_BITS];
    assign entry_by   = rd_data_reg[TALLY_BITS-1:0];
    assign sum_pk     = entry_pk + TALLY_BITS'(1);
    assign sum_by     = entry_by + TALLY_BITS'(len_reg);
    assign out_free   = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        clear_addr_next = clear_addr_reg;
        op_next         = op_reg;
        idx_next        = idx_reg;
        len_next        = len_reg;
        out_valid_next  = out_valid_reg && out_stall;
        status_next     = status_reg;
        pk_out_next     = pk_out_reg;
        by_out_next     = by_out_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = q_idx;
        wr_en           = 1'b0;
        wr_addr         = idx_reg;
        wr_data         = '0;

        unique case (state_reg)
            BK_CLEAR:
            begin
                wr_en           = 1'b1;
                wr_addr         = clear_addr_reg;
                clear_addr_next = clear_addr_reg + 1'b1;
                if (clear_addr_reg == '1)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    rd_en      = 1'b1;
                    op_next    = q_op;
                    idx_next   = q_idx;
                    len_next   = q_len;
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_DONE;
                    pk_out_next    = '0;
                    by_out_next    = '0;
                    state_next     = BK_IDLE;
                    unique case (op_reg)
                        OP_COUNT:
                        begin
                            if (entry_open)
                            begin
                                wr_en       = 1'b1;
                                wr_data     = {1'b1, sum_pk, sum_by};
                                pk_out_next = sum_pk;
                                by_out_next = sum_by;
                            end
                            else
                            begin
                                status_next = ST_ABSENT;
                            end
                        end
                        OP_ADD:
                        begin
                            if (entry_open)
                            begin
                                status_next = ST_PRESENT;
                            end
                            else
                            begin
                                wr_en   = 1'b1;
                                wr_data = {1'b1, {(2*TALLY_BITS){1'b0}}};
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (entry_open)
                            begin
                                wr_en       = 1'b1;
                                wr_data     = {1'b0, entry_pk, entry_by};
                                pk_out_next = entry_pk;
                                by_out_next = entry_by;
                            end
                            else
                            begin
                                status_next = ST_ABSENT;
                            end
                        end
                        OP_NONE:
                        begin
                            status_next = ST_DONE;
                        end
                        default:
                        begin
                            status_next = ST_DONE;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_CLEAR;
            clear_addr_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clear_addr_reg <= clear_addr_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        idx_reg    <= idx_next;
        len_reg    <= len_next;
        status_reg <= status_next;
        pk_out_reg <= pk_out_next;
        by_out_reg <= by_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign bk_status.clearing = (state_reg == BK_CLEAR);
    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign packets_seen       = pk_out_reg;
    assign bytes_seen         = by_out_reg;

endmodule

@@ hw/rtl/flow_packet_byte_counter_table_unit.sv @@
// Top level of the per-flow packet and byte counter table.
`timescale 1ns / 1ps

// Table of 2^ID_BITS counter entries, each an open flag with 64-bit packet and
// byte tallies, held in one single-port-write memory. Each input beat is count
// (mode 0), add (mode 1), remove (mode 2) or a no-op (mode 3) and yields
// exactly one result beat. After reset the block sweeps the memory to close
// every entry, one entry per cycle; in_stall stays high until the sweep ends.
// The front end queues up to two beats; the back end pops a beat and starts
// the registered memory read in BK_IDLE, then does the update, write-back and
// result load in BK_APPLY, and takes no new beat until that is done. A result
// waiting in the output register does not block the next read.

module flow_packet_byte_counter_table_unit
    import fpbc_pkg::*;
#(
    parameter int ID_BITS = 10
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [MODE_BITS-1:0]  mode,
    input  logic [ID_BITS-1:0]    counter_id,
    input  logic [LEN_BITS-1:0]   packet_length,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [1:0]            status,
    output logic [TALLY_BITS-1:0] packets_seen,
    output logic [TALLY_BITS-1:0] bytes_seen
);

    back_status_t        bk_status;
    logic                q_valid;
    op_t                 q_op;
    logic [ID_BITS-1:0]  q_idx;
    logic [LEN_BITS-1:0] q_len;
    logic                q_pop;

    fpbc_front #(
        .ID_BITS (ID_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .mode          (mode),
        .counter_id    (counter_id),
        .packet_length (packet_length),
        .bk_status     (bk_status),
        .q_valid       (q_valid),
        .q_op          (q_op),
        .q_idx         (q_idx),
        .q_len         (q_len),
        .q_pop         (q_pop)
    );

    fpbc_back #(
        .ID_BITS (ID_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_op         (q_op),
        .q_idx        (q_idx),
        .q_len        (q_len),
        .q_pop        (q_pop),
        .bk_status    (bk_status),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .packets_seen (packets_seen),
        .bytes_seen   (bytes_seen)
    );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the flow packet and byte counter table unit.
`timescale 1ns / 1ps

module tb_top
    import fpbc_pkg::*;
();

    localparam int ID_BITS        = 10;
    localparam int TABLE_SIZE     = 1 << ID_BITS;
    localparam int IDLE_PCT       = 24;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 16;

    localparam logic [MODE_BITS-1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        status_t               status;
        logic [TALLY_BITS-1:0] packets;
        logic [TALLY_BITS-1:0] bytes;
    } counter_result_t;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  in_valid      = 1'b0;
    logic                  in_stall;
    logic [MODE_BITS-1:0]  mode          = MODE_COUNT;
    logic [ID_BITS-1:0]    counter_id    = '0;
    logic [LEN_BITS-1:0]   packet_length = '0;
    logic                  out_valid;
    logic                  out_stall     = 1'b0;
    logic [1:0]            status;
    logic [TALLY_BITS-1:0] packets_seen;
    logic [TALLY_BITS-1:0] bytes_seen;

    logic                  idle_en       = 1'b1;
    int                    error_count   = 0;
    int                    beats_sent    = 0;
    int                    results_seen  = 0;
    int                    quiet_cycles  = 0;

    logic                  flow_open  [TABLE_SIZE];
    logic [TALLY_BITS-1:0] flow_pkts  [TABLE_SIZE];
    logic [TALLY_BITS-1:0] flow_bytes [TABLE_SIZE];
    counter_result_t       pending_results[$];

    flow_packet_byte_counter_table_unit #(
        .ID_BITS(ID_BITS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .mode         (mode),
        .counter_id   (counter_id),
        .packet_length(packet_length),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .packets_seen (packets_seen),
        .bytes_seen   (bytes_seen)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            flow_open[i]  = 1'b0;
            flow_pkts[i]  = '0;
            flow_bytes[i] = '0;
        end
    end

    function automatic counter_result_t apply_table_op(input logic [MODE_BITS-1:0] op,
                                                       input logic [ID_BITS-1:0] id,
                                                       input logic [LEN_BITS-1:0] len);
        counter_result_t r;
        r.status  = ST_DONE;
        r.packets = '0;
        r.bytes   = '0;
        case (op)
            MODE_COUNT:
            begin
                if (flow_open[id])
                begin
                    flow_pkts[id]  = flow_pkts[id] + 64'd1;
                    flow_bytes[id] = flow_bytes[id] + {{(TALLY_BITS-LEN_BITS){1'b0}}, len};
                    r.packets      = flow_pkts[id];
                    r.bytes        = flow_bytes[id];
                end
                else
                begin
                    r.status = ST_ABSENT;
                end
            end
            MODE_ADD:
            begin
                if (flow_open[id])
                begin
                    r.status = ST_PRESENT;
                end
                else
                begin
                    flow_open[id]  = 1'b1;
                    flow_pkts[id]  = '0;
                    flow_bytes[id] = '0;
                end
            end
            MODE_REMOVE:
            begin
                if (flow_open[id])
                begin
                    r.packets     = flow_pkts[id];
                    r.bytes       = flow_bytes[id];
                    flow_open[id] = 1'b0;
                end
                else
                begin
                    r.status = ST_ABSENT;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_beat(input logic [MODE_BITS-1:0] op, input logic [ID_BITS-1:0] id,
                             input logic [LEN_BITS-1:0] len);
        while (idle_en && ($urandom_range(0, 99) < IDLE_PCT))
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        mode          <= op;
        counter_id    <= id;
        packet_length <= len;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(apply_table_op(op, id, len));
        beats_sent++;
    endtask

    function automatic logic [ID_BITS-1:0] pick_flow_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return ID_BITS'($urandom_range(0, 7));
        else if (r < 60)
            return ID_BITS'(TABLE_SIZE - 8 + $urandom_range(0, 7));
        else
            return ID_BITS'($urandom_range(0, TABLE_SIZE - 1));
    endfunction

    function automatic logic [LEN_BITS-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        else if (r < 20)
            return '1;
        else
            return LEN_BITS'($urandom_range(0, 65535));
    endfunction

    // Mostly well-formed: add a closed entry, count or remove an open one.
    task automatic send_random_beat();
        logic [ID_BITS-1:0]   id;
        logic [MODE_BITS-1:0] op;
        int                   r;
        id = pick_flow_id();
        r  = $urandom_range(0, 99);
        if (r < 4)
            op = MODE_UNUSED;
        else if (flow_open[id])
            op = (r < 80) ? MODE_COUNT : ((r < 94) ? MODE_REMOVE : MODE_ADD);
        else
            op = (r < 84) ? MODE_ADD : ((r < 92) ? MODE_COUNT : MODE_REMOVE);
        send_beat(op, id, pick_length());
    endtask

    task automatic test_directed_cases();
        send_beat(MODE_ADD,    10'd0,    16'd0);
        send_beat(MODE_ADD,    10'd0,    16'hFFFF);
        send_beat(MODE_COUNT,  10'd0,    16'd0);
        send_beat(MODE_COUNT,  10'd0,    16'hFFFF);
        send_beat(MODE_COUNT,  10'd0,    16'hFFFF);
        send_beat(MODE_UNUSED, 10'd0,    16'hFFFF);
        send_beat(MODE_ADD,    10'd0,    16'd7);
        send_beat(MODE_COUNT,  10'd0,    16'd1);
        send_beat(MODE_REMOVE, 10'd0,    16'd0);
        send_beat(MODE_REMOVE, 10'd0,    16'd0);
        send_beat(MODE_COUNT,  10'd0,    16'd5);
        send_beat(MODE_ADD,    10'd0,    16'd0);
        send_beat(MODE_COUNT,  10'd0,    16'd0);
        send_beat(MODE_COUNT,  10'd1023, 16'hFFFF);
        send_beat(MODE_REMOVE, 10'd1023, 16'hFFFF);
        send_beat(MODE_UNUSED, 10'd1023, 16'd0);
        send_beat(MODE_ADD,    10'd1023, 16'd0);
        send_beat(MODE_COUNT,  10'd1023, 16'hFFFF);
        send_beat(MODE_COUNT,  10'd1023, 16'hFFFF);
        send_beat(MODE_REMOVE, 10'd1023, 16'd0);
        send_beat(MODE_ADD,    10'd1023, 16'd0);
        send_beat(MODE_REMOVE, 10'd1023, 16'd0);
        send_beat(MODE_REMOVE, 10'd0,    16'd0);
    endtask

    task automatic test_random_flows(input int beats);
        for (int i = 0; i < beats; i++)
            send_random_beat();
    endtask

    task automatic test_back_to_back(input int beats);
        idle_en <= 1'b0;
        for (int i = 0; i < beats; i++)
            send_random_beat();
        idle_en <= 1'b1;
    endtask

    task automatic test_drain_open_entries();
        for (int i = 0; i < TABLE_SIZE; i++)
        begin
            if (flow_open[i])
                send_beat(MODE_REMOVE, ID_BITS'(i), pick_length());
        end
        for (int i = 0; i < 8; i++)
            send_beat(MODE_COUNT, ID_BITS'(i), pick_length());
    endtask

    always @(posedge clk)
    begin : check_results
        counter_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                report_mismatch("result beat with nothing expected", 64'(status), 64'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 64'(status), 64'(want.status));
                if (packets_seen !== want.packets)
                    report_mismatch("packets_seen", packets_seen, want.packets);
                if (bytes_seen !== want.bytes)
                    report_mismatch("bytes_seen", bytes_seen, want.bytes);
            end
        end
        out_stall <= idle_en && ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no beat accepted in %0d cycles", quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_cases();
        test_random_flows(600);
        test_back_to_back(250);
        test_drain_open_entries();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d input beats over directed edges, random flows, an unbroken burst",
                 beats_sent);
        $display("and a table drain; %0d result beats compared, %0d mismatches",
                 results_seen, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/fpbc_pkg.sv
hw/rtl/fpbc_front.sv
hw/rtl/fpbc_back.sv
hw/rtl/flow_packet_byte_counter_table_unit.sv
tb/sv/tb_top.sv
